// ----- hdl/nfl_pkg.sv -----
// Shared types, codes and constants of the NFC host frame link.
// No dependencies; every other file of the block imports this package.
package nfl_pkg;

  // Job queue between the front and back parts
  localparam int unsigned JOBQ_DEPTH = 4;

  // Input action codes
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_CMD   = 2'd1;
  localparam logic [1:0] ACT_RX    = 2'd2;
  localparam logic [1:0] ACT_TICK  = 2'd3;

  // Result kind codes
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_RESP   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_TIMEOUT    = 2'd1;
  localparam logic [1:0] ST_BUF_EXCEED = 2'd2;
  localparam logic [1:0] ST_UNEXPECTED = 2'd3;

  // Phase codes
  localparam logic PH_ACK  = 1'b0;
  localparam logic PH_RESP = 1'b1;

  // Frame geometry
  localparam logic [8:0] ACK_BUFFER_BYTES = 9'd8;
  localparam logic [8:0] FRAME_EMPTY_LEN  = 9'd6;
  localparam logic [8:0] FRAME_OVERHEAD   = 9'd7;
  localparam logic [8:0] RESP_MIN_LEN     = 9'd9;
  localparam logic [8:0] RESP_BUF_MIN     = 9'd4;
  localparam logic [8:0] LEN_BYTE_IDX     = 9'd3;

  // Configuration reset values
  localparam logic [8:0]  RBUF_RESET = 9'd262;
  localparam logic [15:0] TMO_RESET  = 16'd1000;

  // Result sequence positions of one job
  localparam int unsigned SEQ_LEN = 16;
  localparam int unsigned POS_W   = $clog2(SEQ_LEN);
  localparam logic [POS_W-1:0] POS_PRE_FF  = POS_W'(2);
  localparam logic [POS_W-1:0] POS_PRE_LEN = POS_W'(3);
  localparam logic [POS_W-1:0] POS_PRE_LCS = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LEAD    = POS_W'(5);
  localparam logic [POS_W-1:0] POS_DCS     = POS_W'(6);
  localparam logic [POS_W-1:0] POS_POST    = POS_W'(7);
  localparam logic [POS_W-1:0] POS_REP     = POS_W'(8);
  localparam logic [POS_W-1:0] POS_CAN     = POS_W'(9);
  localparam logic [POS_W-1:0] POS_CAN_REP = POS_W'(15);

  // One classified input item: which result segments to emit and their data
  typedef struct packed {
    logic       pre;         // preamble, LEN, LCS
    logic       lead;        // one transmit or response byte
    logic       dcs;         // DCS and postamble
    logic       rep;         // status report
    logic       can;         // cancel ACK and its status report
    logic [1:0] lead_kind;
    logic [7:0] byte_a;      // LEN for the preamble, else the lead byte
    logic [7:0] dcs_byte;
    logic [1:0] rep_status;
    logic       rep_phase;
    logic [1:0] can_status;
    logic       can_phase;
  } job_t;

  function automatic logic [SEQ_LEN-1:0] job_mask(job_t j);
    logic [SEQ_LEN-1:0] m;
    m = '0;
    m[4:0]   = {5{j.pre}};
    m[5]     = j.lead;
    m[7:6]   = {2{j.dcs}};
    m[8]     = j.rep;
    m[15:9]  = {7{j.can}};
    return m;
  endfunction

  function automatic logic [7:0] cancel_byte(logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd2, 3'd4: b = 8'hff;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- hdl/nfl_front.sv -----
// Front part of the NFC host frame link: link state machine and item classifier.
// Depends on nfl_pkg; emits one job_t per accepted item that causes results.
module nfl_front
  import nfl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [1:0]  action_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  cmd_length_i,
  input  logic [8:0]  rbuf_i,
  input  logic [15:0] tmo_i,
  output logic        job_push_o,
  output job_t        job_o
);

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_SEND  = 3'd1;
  localparam logic [2:0] MODE_ACK   = 3'd2;
  localparam logic [2:0] MODE_RESP  = 3'd3;
  localparam logic [2:0] MODE_FLUSH = 3'd4;

  logic [2:0]  mode_q, mode_d;
  logic [7:0]  sent_q, sent_d;
  logic [7:0]  cmdlen_q, cmdlen_d;
  logic [7:0]  sum_q, sum_d;
  logic [8:0]  rcnt_q, rcnt_d;
  logic [8:0]  ecnt_q, ecnt_d;
  logic [15:0] wt_q, wt_d;
  job_t        job;

  always_comb begin
    logic       ph;
    logic       reading;
    logic [8:0] sz;
    logic [8:0] limit;
    logic [8:0] ecnt_n;
    logic [8:0] rcnt_n;
    logic [7:0] sum_n;
    logic [7:0] sent_n;
    logic       overflow;

    mode_d   = mode_q;
    sent_d   = sent_q;
    cmdlen_d = cmdlen_q;
    sum_d    = sum_q;
    rcnt_d   = rcnt_q;
    ecnt_d   = ecnt_q;
    wt_d     = wt_q;
    job      = '0;
    job.lead_kind = KIND_TX;

    ph       = (mode_q == MODE_RESP);
    reading  = (mode_q == MODE_ACK) || (mode_q == MODE_RESP);
    sz       = (data_byte_i == 8'd0) ? FRAME_EMPTY_LEN : ({1'b0, data_byte_i} + FRAME_OVERHEAD);
    limit    = ph ? rbuf_i : ACK_BUFFER_BYTES;
    rcnt_n   = rcnt_q + 9'd1;
    sum_n    = sum_q - data_byte_i;
    sent_n   = sent_q + 8'd1;
    overflow = (rcnt_q == LEN_BYTE_IDX) && (sz > limit);
    ecnt_n   = (rcnt_q == LEN_BYTE_IDX) ? sz : ecnt_q;

    unique case (action_i)
      ACT_START: begin
        if (cmd_length_i != 8'd0) begin
          job.pre    = 1'b1;
          job.byte_a = cmd_length_i;
          mode_d     = MODE_SEND;
          cmdlen_d   = cmd_length_i;
          sent_d     = '0;
          sum_d      = '0;
        end
      end
      ACT_CMD: begin
        if (mode_q == MODE_SEND) begin
          job.lead   = 1'b1;
          job.byte_a = data_byte_i;
          sum_d      = sum_n;
          sent_d     = sent_n;
          if (sent_n == cmdlen_q) begin
            job.dcs      = 1'b1;
            job.dcs_byte = sum_n;
            mode_d       = MODE_ACK;
            rcnt_d       = '0;
            ecnt_d       = ACK_BUFFER_BYTES;
            wt_d         = '0;
          end
        end
      end
      ACT_RX: begin
        if (reading) begin
          job.lead      = ph;
          job.lead_kind = KIND_RESP;
          job.byte_a    = data_byte_i;
          rcnt_d        = rcnt_n;
          if (overflow) begin
            job.can        = 1'b1;
            job.can_status = ST_BUF_EXCEED;
            job.can_phase  = ph;
            mode_d         = MODE_FLUSH;
          end else begin
            ecnt_d = ecnt_n;
            if (rcnt_n >= ecnt_n) begin
              job.rep = 1'b1;
              if (!ph) begin
                job.rep_phase = PH_ACK;
                if (ecnt_n != FRAME_EMPTY_LEN) begin
                  job.rep_status = ST_UNEXPECTED;
                  mode_d         = MODE_IDLE;
                end else begin
                  // ACK done: open the response read at once
                  job.rep_status = ST_OK;
                  mode_d         = MODE_RESP;
                  rcnt_d         = '0;
                  ecnt_d         = rbuf_i;
                  wt_d           = '0;
                  if (rbuf_i < RESP_BUF_MIN) begin
                    job.can        = 1'b1;
                    job.can_status = ST_BUF_EXCEED;
                    job.can_phase  = PH_RESP;
                    mode_d         = MODE_FLUSH;
                  end
                end
              end else begin
                job.rep_phase  = PH_RESP;
                job.rep_status = (ecnt_n < RESP_MIN_LEN) ? ST_UNEXPECTED : ST_OK;
                mode_d         = MODE_IDLE;
              end
            end
          end
        end
      end
      ACT_TICK: begin
        if (reading) begin
          if (wt_q >= tmo_i) begin
            job.can        = 1'b1;
            job.can_status = ST_TIMEOUT;
            job.can_phase  = ph;
            mode_d         = MODE_FLUSH;
          end else begin
            wt_d = wt_q + 16'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      sent_q   <= '0;
      cmdlen_q <= '0;
      sum_q    <= '0;
      rcnt_q   <= '0;
      ecnt_q   <= '0;
      wt_q     <= '0;
    end else if (accept_i) begin
      mode_q   <= mode_d;
      sent_q   <= sent_d;
      cmdlen_q <= cmdlen_d;
      sum_q    <= sum_d;
      rcnt_q   <= rcnt_d;
      ecnt_q   <= ecnt_d;
      wt_q     <= wt_d;
    end
  end

  assign job_o      = job;
  assign job_push_o = accept_i && (job.pre || job.lead || job.dcs || job.rep || job.can);

endmodule

// ----- hdl/nfl_jobq.sv -----
// Short job queue between the front and back parts of the NFC host frame link.
// Depends on nfl_pkg for job_t.
module nfl_jobq
  import nfl_pkg::*;
#(
  parameter int unsigned Depth = JOBQ_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  job_t          mem_q [Depth];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + AW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("job pushed into a full queue");
`endif

endmodule

// ----- hdl/nfl_back.sv -----
// Back part of the NFC host frame link: expands jobs into result beats.
// Depends on nfl_pkg; one result beat per cycle through an output register unless the result side stalls the pop.
module nfl_back
  import nfl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       job_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [1:0] kind_o,
  output logic [7:0] byte_value_o,
  output logic [1:0] status_o,
  output logic       phase_o,
  output logic       last_o
);

  job_t               job_q;
  logic [SEQ_LEN-1:0] rem_q, rem_d;
  logic [POS_W-1:0]   pick_pos;
  logic [SEQ_LEN-1:0] pick_oh;
  logic [SEQ_LEN-1:0] rem_after;
  logic               out_free, emit, load;

  logic       out_valid_q, out_valid_d;
  logic [1:0] kind_q, kind_d;
  logic [7:0] byte_q, byte_d;
  logic [1:0] status_q, status_d;
  logic       phase_q, phase_d;
  logic       last_q;

  // Lowest pending position goes next
  always_comb begin
    pick_pos = '0;
    for (int i = SEQ_LEN - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        pick_pos = POS_W'(i);
      end
    end
  end

  assign pick_oh   = SEQ_LEN'(1) << pick_pos;
  assign rem_after = rem_q & ~pick_oh;
  assign out_free  = !out_valid_q || pop_i;
  assign emit      = out_free && (rem_q != '0);
  assign load      = job_valid_i && ((rem_q == '0) || (emit && (rem_after == '0)));
  assign job_pop_o = load;

  always_comb begin
    logic [2:0] can_idx;
    can_idx  = 3'(pick_pos - POS_CAN);
    kind_d   = KIND_TX;
    byte_d   = 8'h00;
    status_d = ST_OK;
    phase_d  = PH_ACK;
    priority if (pick_pos == POS_PRE_FF) begin
      byte_d = 8'hff;
    end else if (pick_pos == POS_PRE_LEN) begin
      byte_d = job_q.byte_a;
    end else if (pick_pos == POS_PRE_LCS) begin
      byte_d = ~job_q.byte_a + 8'd1;
    end else if (pick_pos == POS_LEAD) begin
      kind_d = job_q.lead_kind;
      byte_d = job_q.byte_a;
    end else if (pick_pos == POS_DCS) begin
      byte_d = job_q.dcs_byte;
    end else if (pick_pos == POS_REP) begin
      kind_d   = KIND_STATUS;
      status_d = job_q.rep_status;
      phase_d  = job_q.rep_phase;
    end else if (pick_pos == POS_CAN_REP) begin
      kind_d   = KIND_STATUS;
      status_d = job_q.can_status;
      phase_d  = job_q.can_phase;
    end else if (pick_pos >= POS_CAN) begin
      byte_d = cancel_byte(can_idx);
    end else begin
      // leading preamble zeros and the postamble
      byte_d = 8'h00;
    end
  end

  always_comb begin
    rem_d = rem_q;
    if (load) begin
      rem_d = job_mask(job_i);
    end else if (emit) begin
      rem_d = rem_after;
    end
    out_valid_d = out_free ? emit : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
    if (emit) begin
      kind_q   <= kind_d;
      byte_q   <= byte_d;
      status_q <= status_d;
      phase_q  <= phase_d;
      last_q   <= (rem_after == '0);
    end
  end

  assign empty_o      = !out_valid_q;
  assign kind_o       = kind_q;
  assign byte_value_o = byte_q;
  assign status_o     = status_q;
  assign phase_o      = phase_q;
  assign last_o       = last_q;

`ifndef NO_ASSERTIONS
  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("emitted beat not shown on the result ports");
  a_load_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (rem_q != '0))
    else $error("job loaded without any result beat");
  a_pop_has_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> job_valid_i)
    else $error("job taken from an empty queue");
`endif

endmodule

// ----- hdl/nfc_host_frame_link_top.sv -----
// Top level of the NFC host frame link: configuration registers and wiring.
// Depends on nfl_pkg, nfl_front, nfl_jobq and nfl_back.
//
//   channel   direction  handshake             payload
//   input     in         push / full           action_i, data_byte_i, cmd_length_i
//   result    out        empty / pop           kind_o, byte_value_o, status_o,
//                                              phase_o, last_o
//   config    in/out     psel/penable/pready   paddr, pwdata, prdata
//
// An input beat is classified in the cycle it is accepted, so one item can be
// accepted every cycle while the job queue has room. The back part sends one
// result beat per cycle while the result side pops, and an item causes up to
// 8 result beats; that output sequencer sets the sustained rate. Items that
// cause no result push no job. Reset is asynchronous and active low and needs
// no clearing pass. A stalled pop holds the output register; full rises once
// the job queue holds JobqDepth jobs.
module nfc_host_frame_link_top
  import nfl_pkg::*;
#(
  parameter int unsigned JobqDepth = JOBQ_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action_i,
  input  logic [7:0]  data_byte_i,
  input  logic [7:0]  cmd_length_i,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  byte_value_o,
  output logic [1:0]  status_o,
  output logic        phase_o,
  output logic        last_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Register select bit of the byte address (registers sit at 0 and 4)
  localparam logic REG_RBUF = 1'b0;
  localparam logic REG_TMO  = 1'b1;

  logic [8:0]  rbuf_q;
  logic [15:0] tmo_q;
  logic        cfg_we;
  logic        accept;
  logic        job_push, job_full, job_valid, job_pop;
  job_t        push_job, head_job;

  // Configuration: write in the access phase, zero wait states
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rbuf_q <= RBUF_RESET;
      tmo_q  <= TMO_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_RBUF: rbuf_q <= pwdata[8:0];
        REG_TMO:  tmo_q  <= pwdata[15:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RBUF: prdata = {23'd0, rbuf_q};
      REG_TMO:  prdata = {16'd0, tmo_q};
      default:  prdata = '0;
    endcase
  end

  // Accept an input beat whenever the job queue has room
  assign full   = job_full;
  assign accept = push && !job_full;

  nfl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .action_i     (action_i),
    .data_byte_i  (data_byte_i),
    .cmd_length_i (cmd_length_i),
    .rbuf_i       (rbuf_q),
    .tmo_i        (tmo_q),
    .job_push_o   (job_push),
    .job_o        (push_job)
  );

  // Decouple classification from result sequencing
  nfl_jobq #(
    .Depth (JobqDepth)
  ) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (push_job),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .job_o   (head_job)
  );

  nfl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_i        (head_job),
    .job_pop_o    (job_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .kind_o       (kind_o),
    .byte_value_o (byte_value_o),
    .status_o     (status_o),
    .phase_o      (phase_o),
    .last_o       (last_o)
  );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the NFC host frame link: directed corners, then random
// command/ACK/response exchanges under several register settings, checked beat by beat.
// Depends on nfl_pkg and the nfc_host_frame_link_top RTL only.
module tb_top;
  import nfl_pkg::*;

  localparam int unsigned REG_RESP_BUF = 0;
  localparam int unsigned REG_TIMEOUT  = 1;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned PHASE_GOAL   = 28;
  // cancel ACK, first byte in the top bits
  localparam logic [47:0] CANCEL_ACK = 48'h0000_ff00_ff00;

  typedef enum logic [2:0] {FS_IDLE, FS_SEND, FS_ACK, FS_RESP, FS_FLUSH} frame_state_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [1:0] status;
    logic       phase;
    logic       last;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push;
  logic        full;
  logic [1:0]  action_i;
  logic [7:0]  data_byte_i;
  logic [7:0]  cmd_length_i;
  logic        empty;
  logic        pop;
  logic [1:0]  kind_o;
  logic [7:0]  byte_value_o;
  logic [1:0]  status_o;
  logic        phase_o;
  logic        last_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predicted link state and register copies
  logic [8:0]   reg_resp_buf = RBUF_RESET;
  logic [15:0]  reg_timeout  = TMO_RESET;
  frame_state_e frame_state  = FS_IDLE;
  logic [7:0]   cmd_total    = 8'd0;
  logic [7:0]   cmd_sent     = 8'd0;
  logic [7:0]   cmd_sum      = 8'd0;
  logic [8:0]   rx_count     = 9'd0;
  logic [8:0]   rx_limit     = 9'd0;
  logic [15:0]  read_ticks   = 16'd0;

  beat_t item_beats[$];       // beats caused by the item being predicted
  beat_t link_beats_due[$];   // beats still owed by the link, oldest first

  // Run bookkeeping
  int unsigned src_gap_max = 0;
  int unsigned sink_gap_max = 0;
  int unsigned sink_hold_cycles = 0;
  int unsigned beats_sent = 0;
  int unsigned beats_taken = 0;
  int unsigned beats_checked = 0;
  int unsigned settings_applied = 0;
  int unsigned fail_count = 0;
  int unsigned status_seen [4];

  nfc_host_frame_link_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .action_i     (action_i),
    .data_byte_i  (data_byte_i),
    .cmd_length_i (cmd_length_i),
    .empty        (empty),
    .pop          (pop),
    .kind_o       (kind_o),
    .byte_value_o (byte_value_o),
    .status_o     (status_o),
    .phase_o      (phase_o),
    .last_o       (last_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Link predictor
  // ---------------------------------------------------------------------------
  function automatic void push_beat(logic [1:0] k, logic [7:0] v, logic [1:0] s, logic ph);
    beat_t b;
    b = '{kind: k, value: v, status: s, phase: ph, last: 1'b0};
    item_beats.push_back(b);
  endfunction

  function automatic void push_tx(logic [7:0] v);
    push_beat(KIND_TX, v, ST_OK, PH_ACK);
  endfunction

  function automatic void push_status(logic [1:0] s, logic ph);
    push_beat(KIND_STATUS, 8'h00, s, ph);
  endfunction

  // Emit the cancel ACK and its report, then drop received bytes until a new start
  function automatic void push_cancel(logic [1:0] s, logic ph);
    for (int i = 0; i < 6; i++) push_tx(CANCEL_ACK[47 - 8 * i -: 8]);
    push_status(s, ph);
    frame_state = FS_FLUSH;
  endfunction

  function automatic void open_read(frame_state_e st, logic [8:0] cap);
    frame_state = st;
    rx_count    = 9'd0;
    rx_limit    = cap;
    read_ticks  = 16'd0;
  endfunction

  function automatic void take_reply_byte(logic [7:0] dat);
    logic [8:0] idx;
    logic [8:0] cap;
    logic [8:0] span;
    logic       in_resp;
    idx     = rx_count;
    in_resp = (frame_state == FS_RESP);
    cap     = in_resp ? reg_resp_buf : ACK_BUFFER_BYTES;
    if (in_resp) push_beat(KIND_RESP, dat, ST_OK, PH_ACK);
    rx_count = idx + 9'd1;
    // the LEN byte fixes the frame size
    if (idx == LEN_BYTE_IDX) begin
      span = (dat == 8'h00) ? FRAME_EMPTY_LEN : {1'b0, dat} + FRAME_OVERHEAD;
      if (span > cap) begin
        push_cancel(ST_BUF_EXCEED, in_resp);
        return;
      end
      rx_limit = span;
    end
    if (rx_count < rx_limit) return;
    if (!in_resp) begin
      if (rx_limit != FRAME_EMPTY_LEN) begin
        push_status(ST_UNEXPECTED, PH_ACK);
        frame_state = FS_IDLE;
      end else begin
        // good ACK: open the response read right away
        push_status(ST_OK, PH_ACK);
        open_read(FS_RESP, reg_resp_buf);
        if (reg_resp_buf < RESP_BUF_MIN) push_cancel(ST_BUF_EXCEED, PH_RESP);
      end
    end else begin
      push_status((rx_limit < RESP_MIN_LEN) ? ST_UNEXPECTED : ST_OK, PH_RESP);
      frame_state = FS_IDLE;
    end
  endfunction

  // Predict one accepted input beat; returns 1 unless the link ignores it
  function automatic bit predict_link_beat(logic [1:0] act, logic [7:0] dat, logic [7:0] len);
    bit    taken;
    beat_t b;
    taken = 1'b0;
    item_beats.delete();
    case (act)
      ACT_START: begin
        if (len != 8'd0) begin
          push_tx(8'h00);
          push_tx(8'h00);
          push_tx(8'hff);
          push_tx(len);
          push_tx(8'h00 - len);
          frame_state = FS_SEND;
          cmd_total   = len;
          cmd_sent    = 8'd0;
          cmd_sum     = 8'd0;
          taken       = 1'b1;
        end
      end
      ACT_CMD: begin
        if (frame_state == FS_SEND) begin
          push_tx(dat);
          cmd_sum  = cmd_sum - dat;
          cmd_sent = cmd_sent + 8'd1;
          if (cmd_sent == cmd_total) begin
            push_tx(cmd_sum);
            push_tx(8'h00);
            open_read(FS_ACK, ACK_BUFFER_BYTES);
          end
          taken = 1'b1;
        end
      end
      ACT_RX: begin
        if (frame_state == FS_ACK || frame_state == FS_RESP) begin
          take_reply_byte(dat);
          taken = 1'b1;
        end
      end
      default: begin
        if (frame_state == FS_ACK || frame_state == FS_RESP) begin
          if (read_ticks >= reg_timeout) push_cancel(ST_TIMEOUT, frame_state == FS_RESP);
          else read_ticks = read_ticks + 16'd1;
          taken = 1'b1;
        end
      end
    endcase
    for (int i = 0; i < item_beats.size(); i++) begin
      b      = item_beats[i];
      b.last = (i == item_beats.size() - 1);
      link_beats_due.push_back(b);
    end
    return taken;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Offer one beat after a random gap; predict it at the edge it is taken
  task automatic send_beat(input logic [1:0] act, input logic [7:0] dat, input logic [7:0] len);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push         <= 1'b1;
    action_i     <= act;
    data_byte_i  <= dat;
    cmd_length_i <= len;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    beats_sent++;
    if (predict_link_beat(act, dat, len)) beats_taken++;
  endtask

  // Received byte, sometimes preceded by a few idle ticks
  task automatic send_rx(input logic [7:0] b);
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) send_beat(ACT_TICK, 8'($urandom), 8'($urandom));
    end
    send_beat(ACT_RX, b, 8'($urandom));
  endtask

  // Feed a reply frame of nbytes with the given LEN byte; scramble the rest if asked
  task automatic send_reply(input logic [7:0] len_byte, input int unsigned nbytes,
                            input bit scramble);
    logic [7:0] b;
    for (int i = 0; i < nbytes; i++) begin
      case (i)
        0, 1:    b = 8'h00;
        2:       b = 8'hff;
        3:       b = len_byte;
        4:       b = (len_byte == 8'h00) ? 8'hff : 8'h00 - len_byte;
        default: b = 8'($urandom);
      endcase
      if (scramble && i != 3) b = 8'($urandom);
      send_rx(b);
    end
  endtask

  // Run the current read out of ticks where the timeout is short enough
  task automatic expire_read();
    int unsigned n;
    n = (reg_timeout <= 16'd40) ? int'(reg_timeout) + 1 : $urandom_range(1, 4);
    repeat (n) send_beat(ACT_TICK, 8'($urandom), 8'($urandom));
  endtask

  // One command exchange; most are well formed, some carry one flaw
  task automatic send_frame_exchange();
    int unsigned flaw;
    int unsigned len;
    int unsigned n;
    int unsigned count;
    int          lo;
    flaw = $urandom_range(0, 11);
    len  = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
    send_beat(ACT_START, 8'($urandom), 8'(len));
    if (flaw == 11) begin
      // drop the command halfway; the next start abandons it
      repeat ($urandom_range(0, len - 1)) send_beat(ACT_CMD, 8'($urandom), 8'($urandom));
      return;
    end
    repeat (len) send_beat(ACT_CMD, 8'($urandom), 8'($urandom));
    if (flaw == 10) begin
      expire_read();
      return;
    end
    if (flaw == 6) begin
      // ACK of the wrong size: eight bytes, or too long for the ACK buffer
      n = $urandom_range(0, 1) ? 1 : $urandom_range(2, 255);
      send_reply(8'(n), (n == 1) ? 8 : 6, 1'b1);
      return;
    end
    send_reply(8'h00, 6, $urandom_range(0, 3) == 0);
    if ($urandom_range(0, 5) == 0) wait_link_drained();
    if (flaw == 9) begin
      expire_read();
      return;
    end
    case (flaw)
      7: n = $urandom_range(0, 1);
      8: begin
        lo = int'(reg_resp_buf) - 6;
        if (lo < 0) lo = 0;
        n = (reg_resp_buf < RBUF_RESET) ? $urandom_range(lo, 255) : $urandom_range(2, 8);
      end
      5: n = (reg_resp_buf >= 9 && reg_resp_buf <= 40) ? int'(reg_resp_buf) - 7 : 2;
      default: n = $urandom_range(2, 8);
    endcase
    count = (n == 0) ? 6 : n + 7;
    if (count > reg_resp_buf) count = 6;
    send_reply(8'(n), count, 1'b1);
  endtask

  // Hold the input until every owed beat has come out
  task automatic wait_link_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (link_beats_due.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  task automatic write_reg(input int unsigned idx, input logic [31:0] value);
    logic [31:0] stored;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_RESP_BUF) reg_resp_buf = value[8:0];
    else reg_timeout = value[15:0];
    stored = (idx == REG_RESP_BUF) ? {23'd0, value[8:0]} : {16'd0, value[15:0]};
    // read it back as a back-to-back transfer
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== stored) begin
      $error("prdata: expected %0h, got %0h", stored, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Let the link go idle, then load both registers
  task automatic set_link_registers(input logic [8:0] resp_buf, input logic [15:0] ticks);
    wait_link_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_RESP_BUF, {23'd0, resp_buf});
    write_reg(REG_TIMEOUT, {16'd0, ticks});
    settings_applied++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Hand-picked beats at reset settings: ignored inputs, restart, ACK and reply errors
  task automatic test_directed_corners();
    src_gap_max  = 3;
    sink_gap_max = 3;
    send_beat(ACT_START, 8'h5a, 8'd0);      // zero length: dropped
    send_beat(ACT_CMD, 8'hff, 8'hff);       // no command open
    send_beat(ACT_RX, 8'h00, 8'h00);        // no read open
    send_beat(ACT_TICK, 8'hff, 8'h00);
    send_beat(ACT_START, 8'h00, 8'd255);    // longest command
    send_beat(ACT_CMD, 8'h00, 8'h00);
    send_beat(ACT_START, 8'hff, 8'd1);      // restart while busy
    send_beat(ACT_CMD, 8'hff, 8'd1);        // closes with DCS and postamble
    send_beat(ACT_TICK, 8'h00, 8'h00);
    send_reply(8'h00, 6, 1'b0);             // clean ACK opens the response read
    wait_link_drained();
    send_reply(8'h00, 6, 1'b0);             // empty response: too short
    send_beat(ACT_START, 8'h00, 8'd1);
    send_beat(ACT_CMD, 8'h80, 8'h00);
    send_reply(8'h05, 4, 1'b0);             // ACK too long for its buffer: cancel
    send_beat(ACT_RX, 8'hff, 8'hff);        // swallowed while flushing
  endtask

  // Random exchanges and noise under one register setting and idling profile
  task automatic test_traffic_phase(input logic [8:0] resp_buf, input logic [15:0] ticks,
                                    input int unsigned src_max, input int unsigned sink_max);
    int unsigned goal;
    set_link_registers(resp_buf, ticks);
    src_gap_max  = src_max;
    sink_gap_max = sink_max;
    goal = beats_taken + PHASE_GOAL;
    while (beats_taken < goal) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4)) send_beat(2'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        send_frame_exchange();
      end
    end
  endtask

  // Stall the result side for a long stretch while the input keeps offering beats
  task automatic test_backpressure();
    set_link_registers(9'd40, 16'd500);
    src_gap_max      = 0;
    sink_gap_max     = 2;
    sink_hold_cycles = 200;
    repeat (3) send_frame_exchange();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, then check each popped beat against the oldest one owed
  // ---------------------------------------------------------------------------
  initial begin : result_checker
    beat_t       want;
    int unsigned stall;
    pop <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, sink_gap_max) + sink_hold_cycles;
      sink_hold_cycles = 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      beats_checked++;
      if (kind_o == KIND_STATUS) status_seen[status_o]++;
      if (link_beats_due.size() == 0) begin
        $error("result beat with nothing owed: kind %0d byte %0h", kind_o, byte_value_o);
        fail_count++;
      end else begin
        want = link_beats_due.pop_front();
        if (kind_o !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind_o);
          fail_count++;
        end
        if (byte_value_o !== want.value) begin
          $error("byte_value: expected %0h, got %0h", want.value, byte_value_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
        if (phase_o !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, phase_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    push         <= 1'b0;
    action_i     <= ACT_TICK;
    data_byte_i  <= 8'h00;
    cmd_length_i <= 8'h00;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_traffic_phase(9'd262, 16'd65535, 11, 11);  // widest buffer, longest timeout
    test_traffic_phase(9'd4, 16'd1, 0, 0);          // smallest buffer that fits a response, shortest timeout
    test_traffic_phase(9'd3, 16'd6, 4, 4);          // buffer too small for any response
    test_traffic_phase(9'd20, 16'd8, 11, 0);
    test_backpressure();
    test_traffic_phase(9'd12, 16'd3, 0, 11);
    test_traffic_phase(9'd100, 16'd40, 6, 6);

    // drain, then watch for strays over the back part's latency
    wait_link_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d input beats (%0d acted on) and %0d result beats, %0d settings.",
             beats_sent, beats_taken, beats_checked, settings_applied);
    $display("Status beats: %0d ok, %0d timeout, %0d overflow, %0d unexpected reply.",
             status_seen[ST_OK], status_seen[ST_TIMEOUT], status_seen[ST_BUF_EXCEED],
             status_seen[ST_UNEXPECTED]);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("Run timed out with %0d result beats still owed.", link_beats_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
